>>> hdl/hsvc_pkg.sv
// ============================================================================
// hsvc_pkg
// Shared widths, constants and types of the HSV pixel color classifier.
// ============================================================================
`default_nettype none

package hsvc_pkg;

   // Channel width of one color component
   localparam int PIXEL_BITS = 8;

   // Divider geometry: every quotient that is needed stays below 2**QUO_BITS
   localparam int QUO_BITS = 8;
   localparam int DVD_BITS = PIXEL_BITS + QUO_BITS;

   // Result field widths
   localparam int VOTE_BITS   = 2;
   localparam int HUE_BITS    = 10;
   localparam int SAT_BITS    = 8;
   localparam int BRIGHT_BITS = 8;

   // Working widths for compares
   localparam int HCMP_BITS = HUE_BITS + 1;
   localparam int CMP_BITS  = (PIXEL_BITS > 8) ? PIXEL_BITS : 8;

   // Pipeline depth: front stage, one stage per quotient bit, vote stage
   localparam int LATENCY = QUO_BITS + 2;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 9;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE           = 3'd0,
      CSR_RED_CORE_HUE   = 3'd1,
      CSR_RED_EDGE_HUE   = 3'd2,
      CSR_MIN_VALUE      = 3'd3,
      CSR_LIGHT_HUE      = 3'd4,
      CSR_VIOLET_HUE     = 3'd5,
      CSR_MAX_SATURATION = 3'd6
   } csr_index_type;

   // Hue arithmetic constants (degrees)
   localparam int SECTOR_DEG     = 60;
   localparam int GREEN_BASE_DEG = 120;
   localparam int BLUE_BASE_DEG  = 240;

   // Thresholded-image variant
   localparam int THR_LOW_HUE  = 30;
   localparam int THR_HIGH_HUE = 50;
   localparam int THR_VALUE    = 50;

   // Register reset values
   localparam logic [7:0] RST_RED_CORE_HUE   = 8'd40;
   localparam logic [7:0] RST_RED_EDGE_HUE   = 8'd60;
   localparam logic [7:0] RST_MIN_VALUE      = 8'd50;
   localparam logic [8:0] RST_LIGHT_HUE      = 9'd140;
   localparam logic [8:0] RST_VIOLET_HUE     = 9'd180;
   localparam logic [7:0] RST_MAX_SATURATION = 8'd40;

   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   typedef enum logic [VOTE_BITS-1:0] {
      VOTE_LIGHT = 2'b00,
      VOTE_RED   = 2'b01,
      VOTE_DARK  = 2'b11
   } vote_type;

   // Per-pixel data that rides alongside the dividers
   typedef struct packed {
      sector_type            sector;
      logic                  neg;
      logic [PIXEL_BITS-1:0] mx;
   } side_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] red_core_hue;
      logic [7:0] red_edge_hue;
      logic [7:0] min_value;
      logic [8:0] light_hue;
      logic [8:0] violet_hue;
      logic [7:0] max_saturation;
   } cfg_type;

endpackage

`default_nettype wire

>>> hdl/hsvc_front.sv
// ============================================================================
// hsvc_front
// First pipeline stage: max/min, hue sector, and divider operands.
// ============================================================================
`default_nettype none

module hsvc_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [hsvc_pkg::PIXEL_BITS-1:0]   red,
   input  wire logic [hsvc_pkg::PIXEL_BITS-1:0]   green,
   input  wire logic [hsvc_pkg::PIXEL_BITS-1:0]   blue,
   output logic                                   out_valid,
   output hsvc_pkg::side_type                     out_side,
   output logic [hsvc_pkg::DVD_BITS-1:0]          hue_dividend,
   output logic [hsvc_pkg::PIXEL_BITS-1:0]        hue_divisor,
   output logic [hsvc_pkg::DVD_BITS-1:0]          sat_dividend,
   output logic [hsvc_pkg::PIXEL_BITS-1:0]        sat_divisor
);

   logic [hsvc_pkg::PIXEL_BITS-1:0] mx;
   logic [hsvc_pkg::PIXEL_BITS-1:0] mn;
   logic [hsvc_pkg::PIXEL_BITS-1:0] diff;
   logic [hsvc_pkg::PIXEL_BITS-1:0] num_a;
   logic [hsvc_pkg::PIXEL_BITS-1:0] num_b;
   logic [hsvc_pkg::PIXEL_BITS-1:0] mag;
   logic                            neg;
   hsvc_pkg::sector_type            sector;

   logic                            valid_ff;
   hsvc_pkg::side_type              side_ff,    side_in;
   logic [hsvc_pkg::DVD_BITS-1:0]   hue_dvd_ff, hue_dvd_in;
   logic [hsvc_pkg::PIXEL_BITS-1:0] hue_dvs_ff, hue_dvs_in;
   logic [hsvc_pkg::DVD_BITS-1:0]   sat_dvd_ff, sat_dvd_in;
   logic [hsvc_pkg::PIXEL_BITS-1:0] sat_dvs_ff, sat_dvs_in;

   // Largest and smallest channel
   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx)  mx = blue;
      if (green < mn) mn = green;
      if (blue < mn)  mn = blue;
      diff = mx - mn;
   end

   // Hue sector; a tie of red and green above blue stays in the red sector
   always_comb begin
      if (diff == '0) begin
         sector = hsvc_pkg::SECT_RED;
      end else if ((red > green && red > blue) || (red == green && red > blue)) begin
         sector = hsvc_pkg::SECT_RED;
      end else if (green > blue && green > red) begin
         sector = hsvc_pkg::SECT_GREEN;
      end else begin
         sector = hsvc_pkg::SECT_BLUE;
      end
   end

   // Signed numerator of the in-sector offset, as sign and magnitude
   always_comb begin
      case (sector)
         hsvc_pkg::SECT_RED: begin
            num_a = green;
            num_b = blue;
         end
         hsvc_pkg::SECT_GREEN: begin
            num_a = blue;
            num_b = red;
         end
         default: begin
            num_a = red;
            num_b = green;
         end
      endcase
      neg = num_a < num_b;
      mag = neg ? (num_b - num_a) : (num_a - num_b);
   end

   // Divider operands; a zero divisor only ever meets a zero dividend
   always_comb begin
      side_in.sector = sector;
      side_in.neg    = neg;
      side_in.mx     = mx;
      hue_dvd_in = hsvc_pkg::DVD_BITS'(mag) * hsvc_pkg::DVD_BITS'(hsvc_pkg::SECTOR_DEG);
      hue_dvs_in = (diff == '0) ? hsvc_pkg::PIXEL_BITS'(1) : diff;
      sat_dvd_in = {diff, 8'd0} - hsvc_pkg::DVD_BITS'(diff);
      sat_dvs_in = (mx == '0) ? hsvc_pkg::PIXEL_BITS'(1) : mx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff    <= side_in;
      hue_dvd_ff <= hue_dvd_in;
      hue_dvs_ff <= hue_dvs_in;
      sat_dvd_ff <= sat_dvd_in;
      sat_dvs_ff <= sat_dvs_in;
   end

   assign out_valid    = valid_ff;
   assign out_side     = side_ff;
   assign hue_dividend = hue_dvd_ff;
   assign hue_divisor  = hue_dvs_ff;
   assign sat_dividend = sat_dvd_ff;
   assign sat_divisor  = sat_dvs_ff;

endmodule

`default_nettype wire

>>> hdl/hsvc_div.sv
// ============================================================================
// hsvc_div
// Pipelined restoring divider, one quotient bit per register stage.
// ============================================================================
`default_nettype none

module hsvc_div (
   input  wire logic                              clock,
   input  wire logic [hsvc_pkg::DVD_BITS-1:0]     dividend,
   input  wire logic [hsvc_pkg::PIXEL_BITS-1:0]   divisor,
   output logic [hsvc_pkg::QUO_BITS-1:0]          quotient,
   output logic [hsvc_pkg::PIXEL_BITS-1:0]        remainder
);

   // Quotient is known to fit in QUO_BITS, so the upper dividend bits
   // are already a valid partial remainder.
   logic [hsvc_pkg::PIXEL_BITS-1:0] rem_ff [hsvc_pkg::QUO_BITS];
   logic [hsvc_pkg::PIXEL_BITS-1:0] rem_in [hsvc_pkg::QUO_BITS];
   logic [hsvc_pkg::QUO_BITS-1:0]   low_ff [hsvc_pkg::QUO_BITS];
   logic [hsvc_pkg::QUO_BITS-1:0]   low_in [hsvc_pkg::QUO_BITS];
   logic [hsvc_pkg::QUO_BITS-1:0]   quo_ff [hsvc_pkg::QUO_BITS];
   logic [hsvc_pkg::QUO_BITS-1:0]   quo_in [hsvc_pkg::QUO_BITS];
   logic [hsvc_pkg::PIXEL_BITS-1:0] dvs_ff [hsvc_pkg::QUO_BITS];
   logic [hsvc_pkg::PIXEL_BITS-1:0] dvs_in [hsvc_pkg::QUO_BITS];

   // One compare-and-subtract per stage
   always_comb begin
      for (int s = 0; s < hsvc_pkg::QUO_BITS; s++) begin
         logic [hsvc_pkg::PIXEL_BITS-1:0] src_rem;
         logic [hsvc_pkg::QUO_BITS-1:0]   src_low;
         logic [hsvc_pkg::QUO_BITS-1:0]   src_quo;
         logic [hsvc_pkg::PIXEL_BITS-1:0] src_dvs;
         logic [hsvc_pkg::PIXEL_BITS:0]   shifted;
         logic [hsvc_pkg::PIXEL_BITS:0]   trial;
         logic                            ge;
         if (s == 0) begin
            src_rem = dividend[hsvc_pkg::DVD_BITS-1:hsvc_pkg::QUO_BITS];
            src_low = dividend[hsvc_pkg::QUO_BITS-1:0];
            src_quo = '0;
            src_dvs = divisor;
         end else begin
            src_rem = rem_ff[s-1];
            src_low = low_ff[s-1];
            src_quo = quo_ff[s-1];
            src_dvs = dvs_ff[s-1];
         end
         shifted   = {src_rem, src_low[hsvc_pkg::QUO_BITS-1]};
         trial     = shifted - {1'b0, src_dvs};
         ge        = shifted >= {1'b0, src_dvs};
         rem_in[s] = ge ? trial[hsvc_pkg::PIXEL_BITS-1:0] : shifted[hsvc_pkg::PIXEL_BITS-1:0];
         low_in[s] = {src_low[hsvc_pkg::QUO_BITS-2:0], 1'b0};
         quo_in[s] = {src_quo[hsvc_pkg::QUO_BITS-2:0], ge};
         dvs_in[s] = src_dvs;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff[hsvc_pkg::QUO_BITS-1];
   assign remainder = rem_ff[hsvc_pkg::QUO_BITS-1];

endmodule

`default_nettype wire

>>> hdl/hsvc_vote.sv
// ============================================================================
// hsvc_vote
// Last pipeline stage: floored hue, class vote and the result register.
// ============================================================================
`default_nettype none

module hsvc_vote (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire hsvc_pkg::side_type                side,
   input  wire logic [hsvc_pkg::QUO_BITS-1:0]     hue_quo,
   input  wire logic [hsvc_pkg::PIXEL_BITS-1:0]   hue_rem,
   input  wire logic [hsvc_pkg::QUO_BITS-1:0]     sat_quo,
   input  wire hsvc_pkg::cfg_type                 cfg,
   output logic                                   out_valid,
   output logic signed [hsvc_pkg::VOTE_BITS-1:0]  vote,
   output logic signed [hsvc_pkg::HUE_BITS-1:0]   hue,
   output logic [hsvc_pkg::SAT_BITS-1:0]          saturation,
   output logic [hsvc_pkg::BRIGHT_BITS-1:0]       brightness
);

   // Exact hue lies in [h, h+1); frac says whether it is strictly above h.
   // hue > t  <=> h > t, or h == t with a fraction
   function automatic logic hue_gt(input logic signed [hsvc_pkg::HCMP_BITS-1:0] h,
                                   input logic frac,
                                   input logic signed [hsvc_pkg::HCMP_BITS-1:0] t);
      return (h > t) || (h == t && frac);
   endfunction

   // hue <= t <=> h < t, or h == t with no fraction
   function automatic logic hue_le(input logic signed [hsvc_pkg::HCMP_BITS-1:0] h,
                                   input logic frac,
                                   input logic signed [hsvc_pkg::HCMP_BITS-1:0] t);
      return (h < t) || (h == t && !frac);
   endfunction

   logic signed [hsvc_pkg::HCMP_BITS-1:0] q_ext;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] frac_ext;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] offset;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] base;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] h;
   logic                                  frac;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] core_t;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] edge_t;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] light_t;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] violet_t;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] thr_low_t;
   logic signed [hsvc_pkg::HCMP_BITS-1:0] thr_high_t;
   logic [hsvc_pkg::CMP_BITS-1:0]         mx_ext;
   logic [hsvc_pkg::CMP_BITS-1:0]         vmin_ext;
   logic [hsvc_pkg::CMP_BITS-1:0]         thr_val_ext;
   hsvc_pkg::vote_type                    vote_sel;

   logic                                  valid_ff;
   hsvc_pkg::vote_type                    vote_ff;
   logic signed [hsvc_pkg::HUE_BITS-1:0]  hue_ff,    hue_in;
   logic [hsvc_pkg::SAT_BITS-1:0]         sat_ff,    sat_in;
   logic [hsvc_pkg::BRIGHT_BITS-1:0]      bright_ff, bright_in;

   // Floored hue: base + floor(60 * num / d), num signed
   always_comb begin
      frac     = |hue_rem;
      q_ext    = $signed(hsvc_pkg::HCMP_BITS'(hue_quo));
      frac_ext = $signed(hsvc_pkg::HCMP_BITS'(frac));
      offset   = side.neg ? -(q_ext + frac_ext) : q_ext;
      case (side.sector)
         hsvc_pkg::SECT_RED:   base = '0;
         hsvc_pkg::SECT_GREEN: base = hsvc_pkg::HCMP_BITS'(hsvc_pkg::GREEN_BASE_DEG);
         default:              base = hsvc_pkg::HCMP_BITS'(hsvc_pkg::BLUE_BASE_DEG);
      endcase
      h = base + offset;
   end

   // Thresholds widened to the compare width
   always_comb begin
      core_t      = $signed(hsvc_pkg::HCMP_BITS'(cfg.red_core_hue));
      edge_t      = $signed(hsvc_pkg::HCMP_BITS'(cfg.red_edge_hue));
      light_t     = $signed(hsvc_pkg::HCMP_BITS'(cfg.light_hue));
      violet_t    = $signed(hsvc_pkg::HCMP_BITS'(cfg.violet_hue));
      thr_low_t   = hsvc_pkg::HCMP_BITS'(hsvc_pkg::THR_LOW_HUE);
      thr_high_t  = hsvc_pkg::HCMP_BITS'(hsvc_pkg::THR_HIGH_HUE);
      mx_ext      = hsvc_pkg::CMP_BITS'(side.mx);
      vmin_ext    = hsvc_pkg::CMP_BITS'(cfg.min_value);
      thr_val_ext = hsvc_pkg::CMP_BITS'(hsvc_pkg::THR_VALUE);
   end

   // Class vote, in priority order
   always_comb begin
      if (cfg.mode) begin
         if (h < thr_low_t) begin
            vote_sel = hsvc_pkg::VOTE_RED;
         end else if (h < thr_high_t) begin
            vote_sel = (mx_ext > thr_val_ext) ? hsvc_pkg::VOTE_RED : hsvc_pkg::VOTE_DARK;
         end else begin
            vote_sel = hsvc_pkg::VOTE_DARK;
         end
      end else begin
         if (hue_gt(h, frac, violet_t)) begin
            // floor(sat) < threshold is exact for an integer threshold
            vote_sel = (sat_quo < cfg.max_saturation) ? hsvc_pkg::VOTE_LIGHT
                                                      : hsvc_pkg::VOTE_DARK;
         end else if (hue_gt(h, frac, light_t)) begin
            vote_sel = hsvc_pkg::VOTE_LIGHT;
         end else if (hue_le(h, frac, core_t) && h >= -core_t) begin
            vote_sel = hsvc_pkg::VOTE_RED;
         end else if (hue_le(h, frac, edge_t) && h >= -edge_t) begin
            vote_sel = (mx_ext > vmin_ext) ? hsvc_pkg::VOTE_RED : hsvc_pkg::VOTE_DARK;
         end else if (mx_ext < vmin_ext) begin
            vote_sel = hsvc_pkg::VOTE_DARK;
         end else begin
            vote_sel = hsvc_pkg::VOTE_LIGHT;
         end
      end
   end

   always_comb begin
      hue_in    = h[hsvc_pkg::HUE_BITS-1:0];
      sat_in    = sat_quo[hsvc_pkg::SAT_BITS-1:0];
      bright_in = mx_ext[hsvc_pkg::BRIGHT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      vote_ff   <= vote_sel;
      hue_ff    <= hue_in;
      sat_ff    <= sat_in;
      bright_ff <= bright_in;
   end

   assign out_valid  = valid_ff;
   assign vote       = vote_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign brightness = bright_ff;

endmodule

`default_nettype wire

>>> hdl/hsv_pixel_colour_classifier.sv
// ============================================================================
// hsv_pixel_colour_classifier
// RGB pixel to hue, saturation, value and a red / light / dark class vote.
// ============================================================================
// Usage:
//   Drive req_red/req_green/req_blue with start high for one cycle per pixel.
//   busy is always low, so a pixel is taken on every cycle that start is high
//   and one pixel per clock is sustained.
//   Each transaction produces exactly one result: rsp_valid is high for one
//   cycle with rsp_vote, rsp_hue, rsp_saturation and rsp_brightness.
//   From the accepting edge to the edge that takes the result, a pixel passes
//   one front stage (max/min, sector, operands), eight divider stages
//   (one quotient bit each, hue and saturation dividers side by side) and one
//   vote stage with the result register.
//   The receiver cannot stall; results are presented once and not held.
//   Configuration registers are written through csr_wr_en/csr_index/csr_data
//   and take effect at once; write them only while no pixel is in flight.
//   Reset (synchronous) clears the pipeline valid bits and loads the register
//   defaults; no clearing pass is needed.
// ============================================================================
`default_nettype none

module hsv_pixel_colour_classifier (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [hsvc_pkg::PIXEL_BITS-1:0]       req_red,
   input  wire logic [hsvc_pkg::PIXEL_BITS-1:0]       req_green,
   input  wire logic [hsvc_pkg::PIXEL_BITS-1:0]       req_blue,
   output logic                                       rsp_valid,
   output logic signed [hsvc_pkg::VOTE_BITS-1:0]      rsp_vote,
   output logic signed [hsvc_pkg::HUE_BITS-1:0]       rsp_hue,
   output logic [hsvc_pkg::SAT_BITS-1:0]              rsp_saturation,
   output logic [hsvc_pkg::BRIGHT_BITS-1:0]           rsp_brightness,
   input  wire logic                                  csr_wr_en,
   input  wire logic [hsvc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [hsvc_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   hsvc_pkg::cfg_type               cfg_ff, cfg_in;

   logic                            accept;
   logic                            front_valid;
   hsvc_pkg::side_type              front_side;
   logic [hsvc_pkg::DVD_BITS-1:0]   hue_dvd;
   logic [hsvc_pkg::PIXEL_BITS-1:0] hue_dvs;
   logic [hsvc_pkg::DVD_BITS-1:0]   sat_dvd;
   logic [hsvc_pkg::PIXEL_BITS-1:0] sat_dvs;
   logic [hsvc_pkg::QUO_BITS-1:0]   hue_quo;
   logic [hsvc_pkg::PIXEL_BITS-1:0] hue_rem;
   logic [hsvc_pkg::QUO_BITS-1:0]   sat_quo;
   logic [hsvc_pkg::PIXEL_BITS-1:0] sat_rem;

   logic [hsvc_pkg::QUO_BITS-1:0]   vld_ff,  vld_in;
   hsvc_pkg::side_type              side_ff [hsvc_pkg::QUO_BITS];
   hsvc_pkg::side_type              side_in [hsvc_pkg::QUO_BITS];

   // Fully pipelined: always ready
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (hsvc_pkg::csr_index_type'(csr_index))
            hsvc_pkg::CSR_MODE:           cfg_in.mode           = csr_data[0];
            hsvc_pkg::CSR_RED_CORE_HUE:   cfg_in.red_core_hue   = csr_data[7:0];
            hsvc_pkg::CSR_RED_EDGE_HUE:   cfg_in.red_edge_hue   = csr_data[7:0];
            hsvc_pkg::CSR_MIN_VALUE:      cfg_in.min_value      = csr_data[7:0];
            hsvc_pkg::CSR_LIGHT_HUE:      cfg_in.light_hue      = csr_data[8:0];
            hsvc_pkg::CSR_VIOLET_HUE:     cfg_in.violet_hue     = csr_data[8:0];
            hsvc_pkg::CSR_MAX_SATURATION: cfg_in.max_saturation = csr_data[7:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= 1'b0;
         cfg_ff.red_core_hue   <= hsvc_pkg::RST_RED_CORE_HUE;
         cfg_ff.red_edge_hue   <= hsvc_pkg::RST_RED_EDGE_HUE;
         cfg_ff.min_value      <= hsvc_pkg::RST_MIN_VALUE;
         cfg_ff.light_hue      <= hsvc_pkg::RST_LIGHT_HUE;
         cfg_ff.violet_hue     <= hsvc_pkg::RST_VIOLET_HUE;
         cfg_ff.max_saturation <= hsvc_pkg::RST_MAX_SATURATION;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hsvc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .red          (req_red),
      .green        (req_green),
      .blue         (req_blue),
      .out_valid    (front_valid),
      .out_side     (front_side),
      .hue_dividend (hue_dvd),
      .hue_divisor  (hue_dvs),
      .sat_dividend (sat_dvd),
      .sat_divisor  (sat_dvs)
   );

   hsvc_div u_hue_div (
      .clock     (clock),
      .dividend  (hue_dvd),
      .divisor   (hue_dvs),
      .quotient  (hue_quo),
      .remainder (hue_rem)
   );

   // Saturation remainder is not needed for the vote: the floor alone is compared
   hsvc_div u_sat_div (
      .clock     (clock),
      .dividend  (sat_dvd),
      .divisor   (sat_dvs),
      .quotient  (sat_quo),
      .remainder (sat_rem)
   );

   // Valid bits and side data shadow the divider stages
   always_comb begin
      vld_in = {vld_ff[hsvc_pkg::QUO_BITS-2:0], front_valid};
      for (int s = 0; s < hsvc_pkg::QUO_BITS; s++) begin
         side_in[s] = (s == 0) ? front_side : side_ff[(s == 0) ? 0 : s - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
   end

   hsvc_vote u_vote (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vld_ff[hsvc_pkg::QUO_BITS-1]),
      .side       (side_ff[hsvc_pkg::QUO_BITS-1]),
      .hue_quo    (hue_quo),
      .hue_rem    (hue_rem),
      .sat_quo    (sat_quo),
      .cfg        (cfg_ff),
      .out_valid  (rsp_valid),
      .vote       (rsp_vote),
      .hue        (rsp_hue),
      .saturation (rsp_saturation),
      .brightness (rsp_brightness)
   );

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // Every accepted transaction yields a result after the pipeline latency
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(hsvc_pkg::LATENCY) rsp_valid)
      else $error("result missing after pipeline latency");

   // Hue stays within its signed range, from -60 to 300
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue >= -10'sd60 && rsp_hue <= 10'sd300))
      else $error("hue out of range");

   // Thresholded variant never votes light
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cfg_ff.mode) |-> (rsp_vote != hsvc_pkg::VOTE_LIGHT))
      else $error("light vote in threshold mode");

   // A black pixel leaves both dividers with zero quotient and remainder
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[hsvc_pkg::QUO_BITS-1] && side_ff[hsvc_pkg::QUO_BITS-1].mx == '0)
         |-> (sat_quo == '0 && sat_rem == '0 && hue_quo == '0 && hue_rem == '0))
      else $error("black pixel with nonzero divider output");

endmodule

`default_nettype wire

>>> bench/hsv_pixel_colour_classifier_test.sv
// ============================================================================
// hsv_pixel_colour_classifier_test
// Self-checking bench for the HSV pixel color classifier.
// Pixels go in through the start/busy command port with random gaps. A
// scoreboard predicts vote, hue, saturation and brightness for every
// accepted pixel and checks the strobed results in order. The run steps
// through several register settings: reset values, threshold mode, all-zero
// and all-maximum thresholds, masked wide writes and random settings.
// ============================================================================
`timescale 1ns / 1ps

typedef struct packed {
   logic [hsvc_pkg::PIXEL_BITS-1:0] red;
   logic [hsvc_pkg::PIXEL_BITS-1:0] green;
   logic [hsvc_pkg::PIXEL_BITS-1:0] blue;
} rgb_type;

typedef struct {
   rgb_type                          pixel;
   hsvc_pkg::vote_type               vote;
   logic [hsvc_pkg::HUE_BITS-1:0]    hue;
   logic [hsvc_pkg::SAT_BITS-1:0]    sat;
   logic [hsvc_pkg::BRIGHT_BITS-1:0] bright;
} pixel_class_type;

class pixel_vote_scoreboard;
   localparam int SAT_FULL_SCALE = 255;

   hsvc_pkg::cfg_type cfg;
   pixel_class_type   expected_classes[$];
   int                mismatches;

   function new();
      cfg.mode           = 1'b0;
      cfg.red_core_hue   = hsvc_pkg::RST_RED_CORE_HUE;
      cfg.red_edge_hue   = hsvc_pkg::RST_RED_EDGE_HUE;
      cfg.min_value      = hsvc_pkg::RST_MIN_VALUE;
      cfg.light_hue      = hsvc_pkg::RST_LIGHT_HUE;
      cfg.violet_hue     = hsvc_pkg::RST_VIOLET_HUE;
      cfg.max_saturation = hsvc_pkg::RST_MAX_SATURATION;
      mismatches         = 0;
   endfunction

   // Mirror of a register write; data is cut to the register's width
   function void write_reg(logic [hsvc_pkg::CSR_INDEX_BITS-1:0] idx,
                           logic [hsvc_pkg::CSR_DATA_BITS-1:0] data);
      case (idx)
         hsvc_pkg::CSR_MODE:           cfg.mode           = data[0];
         hsvc_pkg::CSR_RED_CORE_HUE:   cfg.red_core_hue   = data[7:0];
         hsvc_pkg::CSR_RED_EDGE_HUE:   cfg.red_edge_hue   = data[7:0];
         hsvc_pkg::CSR_MIN_VALUE:      cfg.min_value      = data[7:0];
         hsvc_pkg::CSR_LIGHT_HUE:      cfg.light_hue      = data[8:0];
         hsvc_pkg::CSR_VIOLET_HUE:     cfg.violet_hue     = data[8:0];
         hsvc_pkg::CSR_MAX_SATURATION: cfg.max_saturation = data[7:0];
         default: ;
      endcase
   endfunction

   // Hue held as the fraction p/d; every hue threshold test is p against T*d
   function pixel_class_type classify_pixel(rgb_type px);
      pixel_class_type res;
      int r, g, b, mx, mn, d, p, hue_i, sat_i;
      int core_hue, edge_hue, vfloor;
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;

      if (d == 0) begin
         // grey: hue 0
         p = 0;
         d = 1;
      end else if ((r > g && r > b) || (r == g && r > b)) begin
         p = hsvc_pkg::SECTOR_DEG * (g - b);
      end else if (g > b && g > r) begin
         p = hsvc_pkg::GREEN_BASE_DEG * d + hsvc_pkg::SECTOR_DEG * (b - r);
      end else begin
         p = hsvc_pkg::BLUE_BASE_DEG * d + hsvc_pkg::SECTOR_DEG * (r - g);
      end

      // floored division
      hue_i = p / d;
      if (p < 0 && (p % d) != 0) hue_i = hue_i - 1;
      sat_i = (mx == 0) ? 0 : (SAT_FULL_SCALE * (mx - mn)) / mx;

      core_hue = int'(cfg.red_core_hue);
      edge_hue = int'(cfg.red_edge_hue);
      vfloor   = int'(cfg.min_value);
      if (cfg.mode) begin
         if (p < hsvc_pkg::THR_LOW_HUE * d)
            res.vote = hsvc_pkg::VOTE_RED;
         else if (p < hsvc_pkg::THR_HIGH_HUE * d)
            res.vote = (mx > hsvc_pkg::THR_VALUE) ? hsvc_pkg::VOTE_RED : hsvc_pkg::VOTE_DARK;
         else
            res.vote = hsvc_pkg::VOTE_DARK;
      end else if (p > int'(cfg.violet_hue) * d) begin
         res.vote = (SAT_FULL_SCALE * (mx - mn) < int'(cfg.max_saturation) * mx) ?
                    hsvc_pkg::VOTE_LIGHT : hsvc_pkg::VOTE_DARK;
      end else if (p > int'(cfg.light_hue) * d) begin
         res.vote = hsvc_pkg::VOTE_LIGHT;
      end else if (p <= core_hue * d && p >= -core_hue * d) begin
         res.vote = hsvc_pkg::VOTE_RED;
      end else if (p <= edge_hue * d && p >= -edge_hue * d) begin
         res.vote = (mx > vfloor) ? hsvc_pkg::VOTE_RED : hsvc_pkg::VOTE_DARK;
      end else if (mx < vfloor) begin
         res.vote = hsvc_pkg::VOTE_DARK;
      end else begin
         res.vote = hsvc_pkg::VOTE_LIGHT;
      end

      res.pixel  = px;
      res.hue    = hsvc_pkg::HUE_BITS'(hue_i);
      res.sat    = hsvc_pkg::SAT_BITS'(sat_i);
      res.bright = hsvc_pkg::BRIGHT_BITS'(mx);
      return res;
   endfunction

   function void note_pixel(rgb_type px);
      expected_classes.insert(expected_classes.size(), classify_pixel(px));
   endfunction

   function int outstanding();
      return expected_classes.size();
   endfunction

   function void check_result(logic [hsvc_pkg::VOTE_BITS-1:0] vote,
                              logic [hsvc_pkg::HUE_BITS-1:0] hue,
                              logic [hsvc_pkg::SAT_BITS-1:0] sat,
                              logic [hsvc_pkg::BRIGHT_BITS-1:0] bright);
      pixel_class_type want;
      if (expected_classes.size() == 0) begin
         $display("%0t: unexpected result vote %0d hue %0d sat %0d bright %0d", $time,
                  $signed(vote), $signed(hue), sat, bright);
         mismatches++;
         return;
      end
      want = expected_classes.pop_front();
      if (vote !== want.vote) begin
         $display("%0t: rgb %0d,%0d,%0d vote expected %0d actual %0d", $time,
                  want.pixel.red, want.pixel.green, want.pixel.blue,
                  $signed(want.vote), $signed(vote));
         mismatches++;
      end
      if (hue !== want.hue) begin
         $display("%0t: rgb %0d,%0d,%0d hue expected %0d actual %0d", $time,
                  want.pixel.red, want.pixel.green, want.pixel.blue,
                  $signed(want.hue), $signed(hue));
         mismatches++;
      end
      if (sat !== want.sat) begin
         $display("%0t: rgb %0d,%0d,%0d saturation expected %0d actual %0d", $time,
                  want.pixel.red, want.pixel.green, want.pixel.blue, want.sat, sat);
         mismatches++;
      end
      if (bright !== want.bright) begin
         $display("%0t: rgb %0d,%0d,%0d brightness expected %0d actual %0d", $time,
                  want.pixel.red, want.pixel.green, want.pixel.blue, want.bright, bright);
         mismatches++;
      end
   endfunction
endclass

module hsv_pixel_colour_classifier_test;

   localparam logic [hsvc_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int PHASE_PIXELS = 100;

   logic                                      clock = 1'b0;
   logic                                      reset;
   logic                                      start;
   logic                                      busy;
   logic [hsvc_pkg::PIXEL_BITS-1:0]           req_red;
   logic [hsvc_pkg::PIXEL_BITS-1:0]           req_green;
   logic [hsvc_pkg::PIXEL_BITS-1:0]           req_blue;
   logic                                      rsp_valid;
   logic signed [hsvc_pkg::VOTE_BITS-1:0]     rsp_vote;
   logic signed [hsvc_pkg::HUE_BITS-1:0]      rsp_hue;
   logic [hsvc_pkg::SAT_BITS-1:0]             rsp_saturation;
   logic [hsvc_pkg::BRIGHT_BITS-1:0]          rsp_brightness;
   logic                                      csr_wr_en;
   logic [hsvc_pkg::CSR_INDEX_BITS-1:0]       csr_index;
   logic [hsvc_pkg::CSR_DATA_BITS-1:0]        csr_data;

   pixel_vote_scoreboard sb;

   hsv_pixel_colour_classifier dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_vote       (rsp_vote),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // Watch all three ports at the edge: results, register writes, pixels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(rsp_vote, rsp_hue, rsp_saturation, rsp_brightness);
         if (csr_wr_en)
            sb.write_reg(csr_index, csr_data);
         if (start && !busy)
            sb.note_pixel('{req_red, req_green, req_blue});
      end
   end

   // One pixel transaction; returns at the edge that takes it
   task send_pixel(input rgb_type px);
      start     <= 1'b1;
      req_red   <= px.red;
      req_green <= px.green;
      req_blue  <= px.blue;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task write_reg(input logic [hsvc_pkg::CSR_INDEX_BITS-1:0] idx,
                  input logic [hsvc_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task write_all(input int mode_bit, core_hue, edge_hue, vfloor, light, violet, sat_cap);
      write_reg(hsvc_pkg::CSR_MODE, hsvc_pkg::CSR_DATA_BITS'(mode_bit));
      write_reg(hsvc_pkg::CSR_RED_CORE_HUE, hsvc_pkg::CSR_DATA_BITS'(core_hue));
      write_reg(hsvc_pkg::CSR_RED_EDGE_HUE, hsvc_pkg::CSR_DATA_BITS'(edge_hue));
      write_reg(hsvc_pkg::CSR_MIN_VALUE, hsvc_pkg::CSR_DATA_BITS'(vfloor));
      write_reg(hsvc_pkg::CSR_LIGHT_HUE, hsvc_pkg::CSR_DATA_BITS'(light));
      write_reg(hsvc_pkg::CSR_VIOLET_HUE, hsvc_pkg::CSR_DATA_BITS'(violet));
      write_reg(hsvc_pkg::CSR_MAX_SATURATION, hsvc_pkg::CSR_DATA_BITS'(sat_cap));
   endtask

   // Stop sending and wait for every outstanding pixel to come back
   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Mix of pixel shapes aimed at ties, grey, dim and reddish cases
   function rgb_type random_pixel();
      rgb_type px;
      int hi, lo;
      hi = $urandom_range(1, 255);
      lo = $urandom_range(0, hi - 1);
      case ($urandom_range(0, 9))
         4: begin
            px.red   = hi[7:0];
            px.green = hi[7:0];
            px.blue  = hi[7:0];
         end
         5: begin
            case ($urandom_range(0, 5))
               0: px = '{hi[7:0], hi[7:0], lo[7:0]};
               1: px = '{hi[7:0], lo[7:0], hi[7:0]};
               2: px = '{lo[7:0], hi[7:0], hi[7:0]};
               3: px = '{lo[7:0], lo[7:0], hi[7:0]};
               4: px = '{lo[7:0], hi[7:0], lo[7:0]};
               default: px = '{hi[7:0], lo[7:0], lo[7:0]};
            endcase
         end
         6: begin
            px.red   = 8'($urandom_range(0, 70));
            px.green = 8'($urandom_range(0, 70));
            px.blue  = 8'($urandom_range(0, 70));
         end
         7: begin
            px.red   = 8'($urandom_range(40, 255));
            px.green = 8'($urandom_range(0, px.red));
            px.blue  = 8'($urandom_range(0, px.red));
         end
         8: begin
            px.red   = 8'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                               : $urandom_range(0, 1));
            px.green = 8'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                               : $urandom_range(0, 1));
            px.blue  = 8'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                               : $urandom_range(0, 1));
         end
         9: begin
            px.red   = 8'($urandom_range(100, 255));
            px.blue  = 8'($urandom_range(100, 255));
            px.green = 8'($urandom_range(0, 120));
         end
         default: begin
            px.red   = 8'($urandom);
            px.green = 8'($urandom);
            px.blue  = 8'($urandom);
         end
      endcase
      return px;
   endfunction

   // Random pixels with gaps; a middle stretch runs back to back
   task run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (!(i >= 20 && i < 60) && $urandom_range(0, 99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clock);
         end
         send_pixel(random_pixel());
      end
   endtask

   task run_random_settings();
      write_all($urandom_range(0, 1), $urandom_range(0, 180), $urandom_range(0, 180),
                $urandom_range(0, 255), $urandom_range(0, 300), $urandom_range(0, 300),
                $urandom_range(0, 255));
      run_random(PHASE_PIXELS);
      drain();
   endtask

   initial begin
      sb        = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_red   = '0;
      req_green = '0;
      req_blue  = '0;
      csr_wr_en = 1'b0;
      csr_index = hsvc_pkg::CSR_MODE;
      csr_data  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels at the reset settings
      send_pixel('{8'd0, 8'd0, 8'd0});        // black
      send_pixel('{8'd255, 8'd255, 8'd255});  // white
      send_pixel('{8'd128, 8'd128, 8'd128});  // grey
      send_pixel('{8'd1, 8'd0, 8'd0});        // smallest nonzero
      send_pixel('{8'd255, 8'd0, 8'd0});      // pure red
      send_pixel('{8'd0, 8'd255, 8'd0});      // pure green
      send_pixel('{8'd0, 8'd0, 8'd255});      // pure blue
      send_pixel('{8'd200, 8'd200, 8'd10});   // red ties green above blue
      send_pixel('{8'd200, 8'd10, 8'd200});   // red ties blue above green
      send_pixel('{8'd10, 8'd200, 8'd200});   // green ties blue above red
      send_pixel('{8'd255, 8'd0, 8'd1});      // just below zero hue
      send_pixel('{8'd255, 8'd0, 8'd128});    // negative hue, floored
      send_pixel('{8'd255, 8'd170, 8'd0});    // hue exactly on the core limit
      send_pixel('{8'd60, 8'd60, 8'd0});      // edge band, bright enough
      send_pixel('{8'd50, 8'd50, 8'd0});      // edge band, at the value floor
      send_pixel('{8'd40, 8'd10, 8'd10});     // dark but core red
      send_pixel('{8'd30, 8'd20, 8'd40});     // violet range, saturated
      send_pixel('{8'd200, 8'd190, 8'd210});  // violet range, pale
      send_pixel('{8'd0, 8'd128, 8'd255});    // violet range, fully saturated
      send_pixel('{8'd100, 8'd255, 8'd0});    // outside bands, bright
      send_pixel('{8'd30, 8'd40, 8'd10});     // outside bands, dark
      run_random(PHASE_PIXELS);
      drain();

      // Threshold mode
      write_reg(hsvc_pkg::CSR_MODE, 9'd1);
      run_random(PHASE_PIXELS);
      drain();

      // All thresholds at their floor
      write_all(0, 0, 0, 0, 0, 0, 0);
      run_random(PHASE_PIXELS);
      drain();

      // All thresholds at their ceiling
      write_all(0, 180, 180, 255, 300, 300, 255);
      run_random(PHASE_PIXELS);
      drain();

      // Wide data cut to width, plus a write to an unused index
      write_all($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 511));
      write_reg(CSR_UNUSED_INDEX, hsvc_pkg::CSR_DATA_BITS'($urandom_range(0, 511)));
      run_random(PHASE_PIXELS);
      drain();

      repeat (3) run_random_settings();

      repeat (hsvc_pkg::LATENCY + 2) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
hdl/hsvc_pkg.sv
hdl/hsvc_front.sv
hdl/hsvc_div.sv
hdl/hsvc_vote.sv
hdl/hsv_pixel_colour_classifier.sv
bench/hsv_pixel_colour_classifier_test.sv
